>>> hw/rtl/u8sv_pkg.sv
// Package for the UTF-8 stream validator: widths, byte constants, error
// codes and the structs passed between the validator modules.
// No dependencies.
`timescale 1ns / 1ps

package u8sv_pkg;

  // width of the byte position counter
  localparam int POSITION_BITS = 16;
  // width of the error position field on the result port
  localparam int OUT_POS_BITS  = 16;

  typedef logic [POSITION_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  // byte classes
  localparam logic [7:0] BYTE_ASCII_MAX = 8'h7f;
  localparam logic [7:0] BYTE_C0        = 8'hc0;
  localparam logic [7:0] BYTE_C1        = 8'hc1;
  localparam logic [7:0] BYTE_F5        = 8'hf5;
  localparam logic [7:0] BYTE_FF        = 8'hff;
  localparam logic [7:0] CONT_MASK      = 8'hc0;
  localparam logic [7:0] CONT_CODE      = 8'h80;
  localparam logic [7:0] LEAD2_MASK     = 8'he0;
  localparam logic [7:0] LEAD2_CODE     = 8'hc0;
  localparam logic [7:0] LEAD3_MASK     = 8'hf0;
  localparam logic [7:0] LEAD3_CODE     = 8'he0;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MISSING   = 3'd1,
    ERR_FORBIDDEN = 3'd2,
    ERR_STRAY     = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_kind_t;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } item_t;

  // one result item
  typedef struct packed {
    logic                    is_valid;
    err_kind_t               error_kind;
    logic [OUT_POS_BITS-1:0] error_position;
    logic                    zero_byte_seen;
  } result_t;

endpackage

>>> hw/rtl/u8sv_in_reg.sv
// Input register of the UTF-8 stream validator: holds one accepted item
// until the checking stage takes it. Depends on u8sv_pkg.
`timescale 1ns / 1ps

module u8sv_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  u8sv_pkg::item_t in_item,
  input  logic           take,
  output logic           hold_valid,
  output u8sv_pkg::item_t hold_item
);

  logic            valid_r, valid_nxt;
  u8sv_pkg::item_t item_r, item_nxt;

  // room when empty or when the held item leaves this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_ready) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

>>> hw/rtl/u8sv_core.sv
// Checking stage of the UTF-8 stream validator: per-string state and the
// byte check that updates it and forms the verdict. Depends on u8sv_pkg.
`timescale 1ns / 1ps

module u8sv_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  u8sv_pkg::item_t  item,
  output u8sv_pkg::result_t result
);

  logic [1:0]          owed_r, owed_nxt;
  u8sv_pkg::err_kind_t kind_r, kind_nxt;
  u8sv_pkg::pos_t      err_idx_r, err_idx_nxt;
  u8sv_pkg::pos_t      idx_r, idx_nxt;
  logic                zero_r, zero_nxt;

  logic [7:0]          b;
  logic                is_ascii, is_forbidden, is_cont;
  u8sv_pkg::err_kind_t byte_err;
  logic [1:0]          owed_after;
  u8sv_pkg::err_kind_t kind_after, kind_final;
  u8sv_pkg::pos_t      idx_after, idx_final;
  logic                zero_after;
  logic [31:0]         pos_wide;

  assign b = item.data_byte;

  // byte classes
  always_comb begin
    is_ascii     = (b <= u8sv_pkg::BYTE_ASCII_MAX);
    is_forbidden = (b inside {u8sv_pkg::BYTE_C0, u8sv_pkg::BYTE_C1,
                              [u8sv_pkg::BYTE_F5:u8sv_pkg::BYTE_FF]});
    is_cont      = ((b & u8sv_pkg::CONT_MASK) == u8sv_pkg::CONT_CODE);
  end

  // error of this byte and the new owed count
  always_comb begin
    byte_err   = u8sv_pkg::ERR_NONE;
    owed_after = owed_r;
    if (is_ascii) begin
      if (owed_r != 2'd0) byte_err = u8sv_pkg::ERR_MISSING;
      owed_after = 2'd0;
    end else if (is_forbidden) begin
      byte_err   = u8sv_pkg::ERR_FORBIDDEN;
      owed_after = 2'd0;
    end else if (is_cont) begin
      if (owed_r == 2'd0) begin
        byte_err = u8sv_pkg::ERR_STRAY;
      end else begin
        owed_after = owed_r - 2'd1;
      end
    end else begin
      // lead byte sets the length of the new sequence
      if (owed_r != 2'd0) byte_err = u8sv_pkg::ERR_MISSING;
      if ((b & u8sv_pkg::LEAD2_MASK) == u8sv_pkg::LEAD2_CODE) begin
        owed_after = 2'd1;
      end else if ((b & u8sv_pkg::LEAD3_MASK) == u8sv_pkg::LEAD3_CODE) begin
        owed_after = 2'd2;
      end else begin
        owed_after = 2'd3;
      end
    end
  end

  // keep only the first error; truncation checked on the last byte
  always_comb begin
    kind_after = kind_r;
    idx_after  = err_idx_r;
    if (kind_r == u8sv_pkg::ERR_NONE && byte_err != u8sv_pkg::ERR_NONE) begin
      kind_after = byte_err;
      idx_after  = idx_r;
    end
    kind_final = kind_after;
    idx_final  = idx_after;
    if (owed_after != 2'd0 && kind_after == u8sv_pkg::ERR_NONE) begin
      kind_final = u8sv_pkg::ERR_TRUNCATED;
      idx_final  = idx_r;
    end
    zero_after = zero_r || (b == 8'h00);
  end

  // verdict for the string, valid when the last byte steps
  always_comb begin
    pos_wide                = 32'(idx_final);
    result.is_valid         = (kind_final == u8sv_pkg::ERR_NONE);
    result.error_kind       = kind_final;
    result.error_position   = result.is_valid ? '0
                              : pos_wide[u8sv_pkg::OUT_POS_BITS-1:0];
    result.zero_byte_seen   = zero_after;
  end

  // state update, cleared after the last byte
  always_comb begin
    owed_nxt    = owed_r;
    kind_nxt    = kind_r;
    err_idx_nxt = err_idx_r;
    idx_nxt     = idx_r;
    zero_nxt    = zero_r;
    if (step) begin
      if (item.end_of_string) begin
        owed_nxt    = 2'd0;
        kind_nxt    = u8sv_pkg::ERR_NONE;
        err_idx_nxt = '0;
        idx_nxt     = '0;
        zero_nxt    = 1'b0;
      end else begin
        owed_nxt    = owed_after;
        kind_nxt    = kind_after;
        err_idx_nxt = idx_after;
        idx_nxt     = (idx_r != u8sv_pkg::POS_MAX) ? idx_r + 1'b1 : idx_r;
        zero_nxt    = zero_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r    <= 2'd0;
      kind_r    <= u8sv_pkg::ERR_NONE;
      err_idx_r <= '0;
      idx_r     <= '0;
      zero_r    <= 1'b0;
    end else begin
      owed_r    <= owed_nxt;
      kind_r    <= kind_nxt;
      err_idx_r <= err_idx_nxt;
      idx_r     <= idx_nxt;
      zero_r    <= zero_nxt;
    end
  end

endmodule

>>> hw/rtl/u8sv_out_reg.sv
// Result register of the UTF-8 stream validator: holds one verdict until
// the receiver takes it. Depends on u8sv_pkg.
`timescale 1ns / 1ps

module u8sv_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  u8sv_pkg::result_t load_data,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output u8sv_pkg::result_t out_data
);

  logic              valid_r, valid_nxt;
  u8sv_pkg::result_t data_r, data_nxt;

  // free when empty or when the held item is taken this cycle
  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

>>> hw/rtl/utf8_stream_validator.sv
// UTF-8 stream validator, top level.
// Takes a string one byte per item on the in_ channel; in_end_of_string
// marks its last byte. Only the last byte produces a result item on the
// out_ channel: overall validity, kind and byte position of the first
// error, and whether a zero byte occurred. After the last byte the per-string
// state returns to zero, so the next byte starts a new string.
// Path: a last byte is accepted into the input register and is then checked
// from the input register into the result register, where its result is valid.
// Throughput: one byte per cycle while no last byte waits for the result
// register; set by the combinational check between those two registers.
// Receiver stall: bytes that are not the last of a string keep flowing while
// a result waits; a last byte waits in the input register until the result
// register is free, and in_ready drops only then.
// Reset (rst_n low, synchronous) empties both registers and clears the
// string state; no result is pending afterwards.
// Depends on u8sv_pkg, u8sv_in_reg, u8sv_core and u8sv_out_reg.
`timescale 1ns / 1ps

module utf8_stream_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_valid,
  output logic [2:0]  out_error_kind,
  output logic [15:0] out_error_position,
  output logic        out_zero_byte_seen
);

  u8sv_pkg::item_t   in_item;
  u8sv_pkg::item_t   hold_item;
  logic              hold_valid;
  logic              step;
  logic              can_load;
  u8sv_pkg::result_t core_result;
  u8sv_pkg::result_t out_data;

  assign in_item.data_byte     = in_data_byte;
  assign in_item.end_of_string = in_end_of_string;

  // a held byte steps unless it ends a string and the result slot is full
  assign step = hold_valid && (!hold_item.end_of_string || can_load);

  u8sv_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (step),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  u8sv_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (hold_item),
    .result (core_result)
  );

  u8sv_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step && hold_item.end_of_string),
    .load_data (core_result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_is_valid       = out_data.is_valid;
  assign out_error_kind     = out_data.error_kind;
  assign out_error_position = out_data.error_position;
  assign out_zero_byte_seen = out_data.zero_byte_seen;

endmodule

>>> hw/rtl/u8sv_checker.sv
// Port checker for the UTF-8 stream validator, bound to the top level.
// Depends on u8sv_pkg and utf8_stream_validator.
`timescale 1ns / 1ps

module u8sv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_valid,
  input logic [2:0]  out_error_kind,
  input logic [15:0] out_error_position,
  input logic        out_zero_byte_seen
);

  // no result pending right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_valid)
      && $stable(out_error_kind) && $stable(out_error_position)
      && $stable(out_zero_byte_seen))
    else $error("stalled result changed");

  // a valid verdict carries no error
  a_valid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_valid |->
      out_error_kind == u8sv_pkg::ERR_NONE && out_error_position == 16'd0)
    else $error("valid verdict with error fields set");

  // an invalid verdict carries a known error kind
  a_invalid_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_valid |->
      out_error_kind == u8sv_pkg::ERR_MISSING
      || out_error_kind == u8sv_pkg::ERR_FORBIDDEN
      || out_error_kind == u8sv_pkg::ERR_STRAY
      || out_error_kind == u8sv_pkg::ERR_TRUNCATED)
    else $error("invalid verdict without error kind");

endmodule

bind utf8_stream_validator u8sv_checker u_u8sv_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_is_valid       (out_is_valid),
  .out_error_kind     (out_error_kind),
  .out_error_position (out_error_position),
  .out_zero_byte_seen (out_zero_byte_seen)
);
